>>> rtl/core/sstf_disk_request_scheduler_macros.svh
// Assertion helpers used by the scheduler module
`ifndef SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Check a property on every rising edge outside reset
`define SSTF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define SSTF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sstf_pkg.sv
`timescale 1ns / 1ps
package sstf_pkg;

  localparam int MAX_REQ    = 16;
  localparam int ID_BITS    = 4;
  localparam int TRACK_BITS = 16;
  localparam int CNT_BITS   = 5;

  localparam logic [CNT_BITS-1:0] MAX_REQ_CNT = CNT_BITS'(MAX_REQ);

  // Opcodes of an input item
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_FINISH  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_QUEUE_LIMIT     = 2'd0;
  localparam logic [1:0] REG_REQUESTER_COUNT = 2'd1;

  typedef struct packed {
    logic                  opcode;
    logic [ID_BITS-1:0]    requester_id;
    logic [TRACK_BITS-1:0] track;
  } req_item_t;

  typedef struct packed {
    logic                  served;
    logic [ID_BITS-1:0]    served_requester;
    logic [TRACK_BITS-1:0] served_track;
    logic                  rejected;
    logic                  all_done;
  } result_item_t;

  // Command broadcast to the row of cells
  typedef struct packed {
    logic                  wr_req;
    logic                  wr_fin;
    logic                  clr;
    logic [ID_BITS-1:0]    id;
    logic [TRACK_BITS-1:0] track;
  } cell_cmd_t;

  // Context shared by every cell during a scan
  typedef struct packed {
    logic [TRACK_BITS-1:0] head;
    logic [CNT_BITS-1:0]   used;
  } cell_ctx_t;

  // Running scan result handed from cell to cell
  typedef struct packed {
    logic                  found;
    logic [CNT_BITS-1:0]   pend;
    logic [ID_BITS-1:0]    best_id;
    logic [TRACK_BITS-1:0] best_dist;
    logic [TRACK_BITS-1:0] best_track;
  } scan_t;

endpackage

>>> rtl/core/sstf_disk_request_scheduler.sv
`timescale 1ns / 1ps
// Shortest-seek-time-first disk request scheduler.
// Input: an event in item (opcode, requester_id, track) is taken at a rising
// edge with start high and busy low. Opcode request places a track in the
// requester's slot; opcode finish retires the requester.
// Output: one result per event, shown on result for the single cycle in
// which done is high. The receiver cannot hold it off and must take it then.
// Configuration: a write on cfg_index / cfg_data transfers when cfg_valid and
// cfg_ready are both high; cfg_ready is high while no event is in progress.
// Index 0 is the queue limit, index 1 the requester count (reloads live count).
// Sequence: each event passes from transfer through an update state that
// writes the slots, a scan state while the scan walks the row of 16 cells
// (one cell per cycle), and a serve state that serves and clears the chosen
// slot. A new event may be started in the cycle done is high.
// Reset: all slots empty, no requester finished, head at track 0, queue limit
// 1, requester count and live count 16.
module sstf_disk_request_scheduler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  sstf_pkg::req_item_t     item,
  output logic                    done,
  output sstf_pkg::result_item_t  result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [sstf_pkg::CNT_BITS-1:0] cfg_data
);
  import sstf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_SERVE  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [ID_BITS-1:0]    scan_cnt;
  req_item_t             cur;
  logic [CNT_BITS-1:0]   queue_limit;
  logic [CNT_BITS-1:0]   requester_count;
  logic [CNT_BITS-1:0]   live_count;
  logic [TRACK_BITS-1:0] head_track;
  logic                  rej;

  logic [CNT_BITS-1:0]   used;
  logic [MAX_REQ-1:0]    valid_vec;
  logic [MAX_REQ-1:0]    fin_vec;
  logic                  bad_event;
  logic [CNT_BITS-1:0]   target;
  logic                  serve_now;
  cell_cmd_t             cmd;
  cell_ctx_t             ctx;
  scan_t                 scan_link [MAX_REQ+1];

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign used      = (requester_count > MAX_REQ_CNT) ? MAX_REQ_CNT : requester_count;

  // Row of cells: scan enters empty at cell 0 and leaves after the last
  assign scan_link[0] = '0;
  assign ctx.head     = head_track;
  assign ctx.used     = used;

  for (genvar g = 0; g < MAX_REQ; g++) begin : g_cell
    sstf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_index (ID_BITS'(g)),
      .cmd      (cmd),
      .ctx      (ctx),
      .scan_in  (scan_link[g]),
      .scan_out (scan_link[g+1]),
      .valid    (valid_vec[g]),
      .finished (fin_vec[g])
    );
  end

  // Judge the event against the current slot state
  assign bad_event = ({1'b0, cur.requester_id} >= used) ||
                     valid_vec[cur.requester_id] || fin_vec[cur.requester_id];

  // Service decision from the scan result leaving the row
  assign target    = (live_count < queue_limit) ? live_count : queue_limit;
  assign serve_now = (live_count != '0) && scan_link[MAX_REQ].found &&
                     (scan_link[MAX_REQ].pend >= target);

  // Drive the cell command
  always_comb begin
    cmd        = '0;
    cmd.id     = cur.requester_id;
    cmd.track  = cur.track;
    if (state == ST_UPDATE && !bad_event) begin
      cmd.wr_req = (cur.opcode == OP_REQUEST);
      cmd.wr_fin = (cur.opcode == OP_FINISH);
    end else if (state == ST_SERVE && serve_now) begin
      cmd.clr = 1'b1;
      cmd.id  = scan_link[MAX_REQ].best_id;
    end
  end

  // Sequence: update, scan across the row, serve
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_SCAN;
      ST_SCAN:   if (scan_cnt == ID_BITS'(MAX_REQ - 1)) state_next = ST_SERVE;
      ST_SERVE:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + ID_BITS'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  // Capture the event on transfer and its rejection verdict in the update state
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur <= item;
    end
    if (state == ST_UPDATE) begin
      rej <= bad_event;
    end
  end

  // Configuration, live count and head position
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit     <= CNT_BITS'(1);
      requester_count <= MAX_REQ_CNT;
      live_count      <= MAX_REQ_CNT;
      head_track      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUEUE_LIMIT: queue_limit <= cfg_data;
          REG_REQUESTER_COUNT: begin
            requester_count <= cfg_data;
            live_count      <= cfg_data;
          end
          default: ;
        endcase
      end
      if (state == ST_UPDATE && !bad_event && cur.opcode == OP_FINISH &&
          live_count != '0) begin
        live_count <= live_count - CNT_BITS'(1);
      end
      if (state == ST_SERVE && serve_now) begin
        head_track <= scan_link[MAX_REQ].best_track;
      end
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_SERVE);
    end
    if (state == ST_SERVE) begin
      result.served           <= serve_now;
      result.served_requester <= serve_now ? scan_link[MAX_REQ].best_id : '0;
      result.served_track     <= serve_now ? scan_link[MAX_REQ].best_track : '0;
      result.rejected         <= rej;
      result.all_done         <= (live_count == '0);
    end
  end

`include "sstf_disk_request_scheduler_macros.svh"

  `SSTF_CHECK(a_start_busy, (start && !busy) |=> busy, "accepted event did not start work")
  `SSTF_CHECK(a_done_idle, done |-> !busy, "result shown while still busy")
  `SSTF_CHECK(a_served_live, (done && result.served) |-> !result.all_done, "served with no live requesters")
  `SSTF_CHECK_ALWAYS(a_one_cmd, $countones({cmd.wr_req, cmd.wr_fin, cmd.clr}) <= 1, "several cell commands at once")

endmodule

>>> rtl/core/sstf_cell.sv
`timescale 1ns / 1ps
module sstf_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sstf_pkg::ID_BITS-1:0]   my_index,
  input  sstf_pkg::cell_cmd_t            cmd,
  input  sstf_pkg::cell_ctx_t            ctx,
  input  sstf_pkg::scan_t                scan_in,
  output sstf_pkg::scan_t                scan_out,
  output logic                           valid,
  output logic                           finished
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] trk;
  logic [TRACK_BITS-1:0] seek;
  logic                  hit;
  logic                  active;
  logic                  better;
  scan_t                 scan_next;

  assign hit    = (cmd.id == my_index);
  assign active = ({1'b0, my_index} < ctx.used);

  // Hold the slot and the finished mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      finished <= 1'b0;
    end else if (hit) begin
      if (cmd.wr_req) begin
        valid <= 1'b1;
      end
      if (cmd.wr_fin) begin
        finished <= 1'b1;
      end
      if (cmd.clr) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.wr_req) begin
      trk <= cmd.track;
    end
  end

  // Fold this slot into the running count and nearest-track choice
  always_comb begin
    seek      = (trk >= ctx.head) ? (trk - ctx.head) : (ctx.head - trk);
    better    = !scan_in.found || (seek < scan_in.best_dist);
    scan_next = scan_in;
    if (valid && active) begin
      scan_next.pend = scan_in.pend + CNT_BITS'(1);
      if (better) begin
        scan_next.found      = 1'b1;
        scan_next.best_id    = my_index;
        scan_next.best_dist  = seek;
        scan_next.best_track = trk;
      end
    end
  end

  // Advance the scan by one cell each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.found <= 1'b0;
      scan_out.pend  <= '0;
    end else begin
      scan_out.found <= scan_next.found;
      scan_out.pend  <= scan_next.pend;
    end
    scan_out.best_id    <= scan_next.best_id;
    scan_out.best_dist  <= scan_next.best_dist;
    scan_out.best_track <= scan_next.best_track;
  end

endmodule
